>>> rtl/chm_pkg.sv
// chm_pkg: constants, codes and the hash mix for the coordinate id map.
// Used by chm_hash, coordinate_hash_id_map, chm_checker and the testbench.
`timescale 1ns / 1ps
package chm_pkg;
  localparam int unsigned DimsDef       = 4;
  localparam int unsigned BinsDef       = 1024;
  localparam int unsigned WaysDef       = 4;
  localparam int unsigned MaxEntriesDef = 4096;
  localparam int unsigned NumCin        = 4;
  localparam int unsigned KindW         = 3;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned IdW           = 12;
  localparam int unsigned CoordW        = 32;

  localparam logic [KindW-1:0] KindLookup   = 3'd0;
  localparam logic [KindW-1:0] KindLookupIns = 3'd1;
  localparam logic [KindW-1:0] KindInsert   = 3'd2;
  localparam logic [KindW-1:0] KindRead     = 3'd3;
  localparam logic [KindW-1:0] KindClear    = 3'd4;

  localparam logic [StatusW-1:0] StHit     = 3'd0;
  localparam logic [StatusW-1:0] StMiss    = 3'd1;
  localparam logic [StatusW-1:0] StCreated = 3'd2;
  localparam logic [StatusW-1:0] StFull    = 3'd3;
  localparam logic [StatusW-1:0] StBadId   = 3'd4;

  function automatic logic [31:0] mix32(input logic [31:0] k_in);
    logic [31:0] k;
    k = k_in;
    k = k + (k << 12);
    k = k ^ (k >> 22);
    k = k + (k << 4);
    k = k ^ (k >> 9);
    k = k + (k << 10);
    k = k ^ (k >> 2);
    k = k + (k << 7);
    k = k ^ (k >> 12);
    return k;
  endfunction
endpackage

>>> rtl/chm_ram.sv
// chm_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module chm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/chm_hash.sv
// chm_hash: two-stage bin index computation (per-dimension mix, then final mix).
// Depends on chm_pkg.
`timescale 1ns / 1ps
module chm_hash #(
  parameter int unsigned Dims = chm_pkg::DimsDef,
  parameter int unsigned Bins = chm_pkg::BinsDef
) (
  input  logic                      clk_i,
  input  logic [Dims-1:0][31:0]     coord_i,
  output logic [$clog2(Bins)-1:0]   bin_o
);
  import chm_pkg::*;
  logic [31:0] sum_q, sum_d;
  logic [$clog2(Bins)-1:0] bin_q;
  logic [31:0] fin;
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < Dims; i++) sum_d = sum_d + (mix32(coord_i[i]) << i);
  end
  assign fin = mix32(sum_q);
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    bin_q <= fin[$clog2(Bins)-1:0];
  end
  assign bin_o = bin_q;
endmodule

>>> rtl/coordinate_hash_id_map.sv
// coordinate_hash_id_map: top level, sequencer and memories of the id map.
// Depends on chm_pkg, chm_hash, chm_ram.
//
// One request in, one result out. A request is taken when in_valid_i is high
// and in_stall_o low. The result shows on out_valid_o with its fields and holds
// while out_stall_i is high. One request is in work at a time.
// Steps, from the accepting edge to out_valid_o:
//   lookup/insert: two hash stages, fill read, fill capture, decide and
//   output, with a slot read, row read and compare for each way compared;
//   a hit stops the walk. Worst case is a full walk over all WAYS ways.
//   read_coords: row read, then output; a bad id or an unused kind: output.
//   clear: sweeps the fill RAM one bin a cycle, then output.
// The next request can be taken in the cycle after the result has been
// loaded into the output register.
// The bucket walk through the slot and coordinate RAMs sets the rate.
// The output register parts the two sides: while the receiver stalls a result,
// the next request is taken and worked on, and waits for the register to free.
// After reset the block first runs the same sweep with in_stall_o high.
`timescale 1ns / 1ps
module coordinate_hash_id_map #(
  parameter int unsigned DIMS        = chm_pkg::DimsDef,
  parameter int unsigned BINS        = chm_pkg::BinsDef,
  parameter int unsigned WAYS        = chm_pkg::WaysDef,
  parameter int unsigned MAX_ENTRIES = chm_pkg::MaxEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [chm_pkg::KindW-1:0]   kind_i,
  input  logic [31:0]                 coord_0_i,
  input  logic [31:0]                 coord_1_i,
  input  logic [31:0]                 coord_2_i,
  input  logic [31:0]                 coord_3_i,
  input  logic [chm_pkg::IdW-1:0]     query_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [chm_pkg::StatusW-1:0] status_o,
  output logic [chm_pkg::IdW-1:0]     state_id_o,
  output logic [31:0]                 out_coord_0_o,
  output logic [31:0]                 out_coord_1_o,
  output logic [31:0]                 out_coord_2_o,
  output logic [31:0]                 out_coord_3_o
);
  import chm_pkg::*;
  localparam int unsigned BinW  = $clog2(BINS);
  localparam int unsigned FillW = $clog2(WAYS + 1);
  localparam int unsigned EntW  = $clog2(MAX_ENTRIES);
  localparam int unsigned NidW  = EntW + 1;
  localparam int unsigned SlotD = BINS * WAYS;
  localparam int unsigned SlotA = $clog2(SlotD);
  localparam int unsigned RowW  = DIMS * 32;
  localparam logic [BinW-1:0] BINW_LAST = BinW'(BINS - 1);

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_H1 = 4'd2, S_H2 = 4'd3,
    S_FILL = 4'd4, S_WAY = 4'd5, S_SLOT = 4'd6, S_ROW = 4'd7, S_RD = 4'd8,
    S_OUT = 4'd9, S_CLR = 4'd10, S_CNT = 4'd11;

  logic [3:0] st_q, st_d;
  logic [KindW-1:0] kind_q;
  logic [DIMS-1:0][31:0] crd_q, crd_d;
  logic [EntW-1:0] qid_q;
  logic [BinW-1:0] bin_w, bin_q, clr_q;
  logic [NidW-1:0] nid_q;
  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] way_q;
  logic out_v_q;
  logic [StatusW-1:0] res_st_q, st_out_q;
  logic [IdW-1:0] res_id_q, id_out_q;
  logic [3:0][31:0] res_oc_q, oc_q;

  // fill RAM
  logic f_we; logic [BinW-1:0] f_wa, f_ra; logic [FillW-1:0] f_wd, f_rd;
  // slot RAM
  logic s_we; logic [SlotA-1:0] s_wa, s_ra; logic [EntW-1:0] s_wd, s_rd;
  // coordinate RAM, one row per id
  logic c_we; logic [EntW-1:0] c_wa, c_ra; logic [RowW-1:0] c_wd, c_rd;

  chm_ram #(.Width(FillW), .Depth(BINS)) u_fill (.clk_i, .we_i(f_we),
    .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd));
  chm_ram #(.Width(EntW), .Depth(SlotD)) u_slot (.clk_i, .we_i(s_we),
    .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  chm_ram #(.Width(RowW), .Depth(MAX_ENTRIES)) u_crd (.clk_i, .we_i(c_we),
    .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));

  chm_hash #(.Dims(DIMS), .Bins(BINS)) u_hash (.clk_i, .coord_i(crd_q), .bin_o(bin_w));

  logic accept, can_add, match, is_ins, rd_bad, walk_on, out_load;
  assign in_stall_o = (st_q != S_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign can_add = (fill_q < FillW'(WAYS)) && (nid_q < NidW'(MAX_ENTRIES));
  assign match = (c_rd == RowW'(crd_q));
  assign is_ins = (kind_q == KindLookupIns) || (kind_q == KindInsert);
  assign rd_bad = !(32'(query_id_i) < 32'(nid_q) && 32'(query_id_i) < MAX_ENTRIES);
  // insert never walks the bin
  assign walk_on = (kind_q != KindInsert) && (way_q < fill_q);
  assign out_load = (st_q == S_OUT) && (!out_v_q || !out_stall_i);

  logic [SlotA-1:0] slot_base;
  assign slot_base = SlotA'(bin_q) * SlotA'(WAYS);

  always_comb begin
    f_we = 1'b0; f_wa = bin_q; f_wd = fill_q + FillW'(1); f_ra = bin_w;
    s_we = 1'b0; s_wa = slot_base + SlotA'(fill_q); s_wd = nid_q[EntW-1:0];
    s_ra = slot_base + SlotA'(way_q);
    c_we = 1'b0; c_wa = nid_q[EntW-1:0]; c_wd = RowW'(crd_q);
    c_ra = (st_q == S_IDLE) ? EntW'(query_id_i) : s_rd;
    st_d = st_q;
    // dimensions above the four ports read as zero
    crd_d = '0;
    crd_d[0] = coord_0_i;
    if (DIMS > 1) crd_d[1 % DIMS] = coord_1_i;
    if (DIMS > 2) crd_d[2 % DIMS] = coord_2_i;
    if (DIMS > 3) crd_d[3 % DIMS] = coord_3_i;
    if (st_q == S_INIT || st_q == S_CLR) begin
      f_we = 1'b1; f_wa = clr_q; f_wd = '0;
    end
    if (st_q == S_WAY && !walk_on && is_ins && can_add) begin
      f_we = 1'b1; s_we = 1'b1; c_we = 1'b1;
    end
    if (st_q == S_IDLE && accept) begin
      case (kind_i)
        KindRead: st_d = rd_bad ? S_OUT : S_RD;
        KindClear: st_d = S_CLR;
        KindLookup, KindLookupIns, KindInsert: st_d = S_H1;
        default: st_d = S_OUT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; clr_q <= '0; nid_q <= '0; out_v_q <= 1'b0;
      st_out_q <= StMiss; id_out_q <= '0; oc_q <= '0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
        st_out_q <= res_st_q; id_out_q <= res_id_q; oc_q <= res_oc_q;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (st_q)
        S_INIT: begin
          clr_q <= clr_q + BinW'(1);
          if (clr_q == BINW_LAST) st_q <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          kind_q <= kind_i;
          crd_q <= crd_d;
          qid_q <= EntW'(query_id_i);
          res_id_q <= '0; res_oc_q <= '0;
          if (kind_i == KindRead && rd_bad) res_st_q <= StBadId;
          else if (kind_i == KindClear) res_st_q <= StHit;
          else res_st_q <= StMiss;
          st_q <= st_d;
        end
        S_H1: st_q <= S_H2;
        S_H2: st_q <= S_FILL;
        // hash output is valid here; fill read is in flight
        S_FILL: begin bin_q <= bin_w; st_q <= S_CNT; end
        S_CNT: begin
          fill_q <= (f_rd > FillW'(WAYS)) ? FillW'(WAYS) : f_rd;
          way_q <= '0;
          st_q <= S_WAY;
        end
        S_WAY: begin
          if (walk_on) st_q <= S_SLOT;
          else begin
            if (is_ins && can_add) begin
              nid_q <= nid_q + NidW'(1);
              res_st_q <= StCreated; res_id_q <= IdW'(nid_q);
            end else if (is_ins) res_st_q <= StFull;
            st_q <= S_OUT;
          end
        end
        S_SLOT: st_q <= S_ROW;
        S_ROW: begin
          if (match) begin
            res_st_q <= StHit; res_id_q <= IdW'(s_rd); st_q <= S_OUT;
          end else begin
            way_q <= way_q + FillW'(1);
            st_q <= S_WAY;
          end
        end
        S_RD: begin
          res_st_q <= StHit; res_id_q <= IdW'(qid_q);
          res_oc_q[0] <= c_rd[31:0];
          if (DIMS > 1) res_oc_q[1] <= c_rd[32*(1%DIMS)+:32];
          if (DIMS > 2) res_oc_q[2] <= c_rd[32*(2%DIMS)+:32];
          if (DIMS > 3) res_oc_q[3] <= c_rd[32*(3%DIMS)+:32];
          st_q <= S_OUT;
        end
        S_CLR: begin
          clr_q <= clr_q + BinW'(1);
          if (clr_q == BINW_LAST) begin nid_q <= '0; st_q <= S_OUT; end
        end
        S_OUT: if (out_load) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o = st_out_q;
  assign state_id_o = id_out_q;
  assign out_coord_0_o = oc_q[0];
  assign out_coord_1_o = oc_q[1];
  assign out_coord_2_o = oc_q[2];
  assign out_coord_3_o = oc_q[3];
endmodule

>>> rtl/chm_checker.sv
// chm_checker: port-level checks for coordinate_hash_id_map, bound to the top.
// Depends on chm_pkg.
`timescale 1ns / 1ps
module chm_checker (
  input logic clk_i, rst_ni, in_valid_i, in_stall_o, out_valid_o, out_stall_i,
  input logic [2:0] status_o
);
  import chm_pkg::*;
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StBadId) else $error("bad status");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second request taken");
endmodule

bind coordinate_hash_id_map chm_checker u_chk (.clk_i, .rst_ni, .in_valid_i,
  .in_stall_o, .out_valid_o, .out_stall_i, .status_o);

>>> tb/chm_map_checker.sv
// chm_map_checker: watches both channels of coordinate_hash_id_map, keeps its own
// copy of the bins and entries, and compares every result. Depends on chm_pkg.
`timescale 1ns / 1ps
module chm_map_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [31:0] coord_0_i,
  input  logic [31:0] coord_1_i,
  input  logic [31:0] coord_2_i,
  input  logic [31:0] coord_3_i,
  input  logic [11:0] query_id_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [11:0] state_id_i,
  input  logic [31:0] out_coord_0_i,
  input  logic [31:0] out_coord_1_i,
  input  logic [31:0] out_coord_2_i,
  input  logic [31:0] out_coord_3_i,
  output int          errors_o,
  output int          pending_o
);
  import chm_pkg::*;

  localparam int unsigned NBins = BinsDef;
  localparam int unsigned NWays = WaysDef;
  localparam int unsigned NIds  = MaxEntriesDef;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
    logic [3:0][31:0]   coord;
  } map_result_t;

  int unsigned  fill_cnt [NBins];
  int unsigned  way_ids  [NBins*NWays];
  logic [31:0]  id_coord [NIds][4];
  int unsigned  next_id;
  map_result_t  expected_q[$];

  function automatic logic [31:0] jenkins(input logic [31:0] v);
    logic [31:0] k;
    k = v;
    k += k << 12;  k ^= k >> 22;
    k += k << 4;   k ^= k >> 9;
    k += k << 10;  k ^= k >> 2;
    k += k << 7;   k ^= k >> 12;
    return k;
  endfunction

  function automatic int unsigned bin_index(input logic [3:0][31:0] c);
    logic [31:0] sum;
    sum = '0;
    for (int d = 0; d < 4; d++) sum += jenkins(c[d]) << d;
    return jenkins(sum) & (NBins - 1);
  endfunction

  task automatic map_request(input logic [2:0] kind, input logic [3:0][31:0] c,
                             input logic [11:0] qid, output map_result_t r);
    int unsigned b, n;
    bit          found;
    r = '0;
    r.status = StMiss;
    b = bin_index(c);
    n = fill_cnt[b];
    found = 0;
    if (kind == KindLookup || kind == KindLookupIns) begin
      for (int w = 0; w < n && !found; w++) begin
        int unsigned cand;
        cand = way_ids[b*NWays + w];
        if (id_coord[cand][0] == c[0] && id_coord[cand][1] == c[1] &&
            id_coord[cand][2] == c[2] && id_coord[cand][3] == c[3]) begin
          found = 1;
          r.status = StHit;
          r.id = cand[IdW-1:0];
        end
      end
    end
    if ((kind == KindLookupIns && !found) || kind == KindInsert) begin
      if (n >= NWays || next_id >= NIds) begin
        r.status = StFull;
      end else begin
        for (int d = 0; d < 4; d++) id_coord[next_id][d] = c[d];
        way_ids[b*NWays + n] = next_id;
        fill_cnt[b] = n + 1;
        r.status = StCreated;
        r.id = next_id[IdW-1:0];
        next_id++;
      end
    end
    if (kind == KindRead) begin
      if (qid < next_id) begin
        r.status = StHit;
        r.id = qid;
        for (int d = 0; d < 4; d++) r.coord[d] = id_coord[qid][d];
      end else begin
        r.status = StBadId;
      end
    end
    if (kind == KindClear) begin
      foreach (fill_cnt[i]) fill_cnt[i] = 0;
      next_id = 0;
      r.status = StHit;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    next_id = 0;
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
  end

  always @(posedge clk_i) begin
    map_result_t r, e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        map_request(kind_i, {coord_3_i, coord_2_i, coord_1_i, coord_0_i}, query_id_i, r);
        expected_q = {expected_q, r};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result status", 32'(status_i), '0);
        end else begin
          e = expected_q.pop_front();
          if (status_i !== e.status)
            report("status", 32'(status_i), 32'(e.status));
          if (state_id_i !== e.id) report("state_id", 32'(state_id_i), 32'(e.id));
          if (out_coord_0_i !== e.coord[0]) report("out_coord_0", out_coord_0_i, e.coord[0]);
          if (out_coord_1_i !== e.coord[1]) report("out_coord_1", out_coord_1_i, e.coord[1]);
          if (out_coord_2_i !== e.coord[2]) report("out_coord_2", out_coord_2_i, e.coord[2]);
          if (out_coord_3_i !== e.coord[3]) report("out_coord_3", out_coord_3_i, e.coord[3]);
        end
      end
      pending_o = expected_q.size();
    end
  end
endmodule

>>> tb/tb_coordinate_hash_id_map.sv
// tb_coordinate_hash_id_map: request stimulus, stalls and verdict for the id map.
// Depends on chm_pkg, coordinate_hash_id_map and chm_map_checker.
`timescale 1ns / 1ps
module tb_coordinate_hash_id_map;
  import chm_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  kind_i = '0;
  logic [31:0] coord_0_i = '0, coord_1_i = '0, coord_2_i = '0, coord_3_i = '0;
  logic [11:0] query_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  status_o;
  logic [11:0] state_id_o;
  logic [31:0] out_coord_0_o, out_coord_1_o, out_coord_2_o, out_coord_3_o;
  int          errors, pending;
  bit          quiet = 0;
  logic [31:0] pool [16];
  int unsigned bin_used [BinsDef];

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  coordinate_hash_id_map u_top (.*);

  chm_map_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i,
    .coord_0_i, .coord_1_i, .coord_2_i, .coord_3_i, .query_id_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .state_id_i(state_id_o), .out_coord_0_i(out_coord_0_o),
    .out_coord_1_i(out_coord_1_o), .out_coord_2_i(out_coord_2_o),
    .out_coord_3_i(out_coord_3_o), .errors_o(errors), .pending_o(pending)
  );

  always @(negedge clk_i) out_stall_i <= !quiet && ($urandom_range(0, 99) < 11);

  // drive at negedge, check stall just before the rising edge
  task automatic send(input logic [2:0] kind, input logic [31:0] c0, c1, c2, c3,
                      input logic [11:0] qid);
    bit stalled;
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    in_valid_i = 1;
    kind_i = kind;
    coord_0_i = c0; coord_1_i = c1; coord_2_i = c2; coord_3_i = c3;
    query_id_i = qid;
    do begin
      #5 stalled = in_stall_o;
      @(posedge clk_i);
      if (stalled) @(negedge clk_i);
    end while (stalled);
    @(negedge clk_i) in_valid_i = 0;
  endtask

  function automatic logic [31:0] pick_coord();
    return ($urandom_range(0, 3) == 0) ? $urandom() : pool[$urandom_range(0, 15)];
  endfunction

  initial begin
    logic [3:0][31:0] c;
    int unsigned k, placed;
    foreach (pool[i]) pool[i] = $urandom();
    pool[0] = '0;
    pool[1] = '1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    // directed
    send(KindLookup, 0, 0, 0, 0, 0);
    send(KindLookupIns, 0, 0, 0, 0, 0);
    send(KindLookupIns, '1, '1, '1, '1, 0);
    send(KindLookup, 0, 0, 0, 0, 0);
    send(KindLookupIns, '1, '1, '1, '1, 0);
    repeat (4) send(KindInsert, 0, 0, 0, 0, 0);  // duplicates until the bin is full
    send(KindLookup, 0, 0, 0, 0, 0);
    send(KindRead, '1, 0, '1, 0, 1);
    send(KindRead, 0, 0, 0, 0, 12'hfff);
    send(3'd5, 1, 2, 3, 4, 5);
    send(3'd6, 0, 0, 0, 0, 0);
    send(3'd7, '1, '1, '1, '1, '1);
    send(KindClear, 0, 0, 0, 0, 0);
    send(KindLookup, 0, 0, 0, 0, 0);
    send(KindRead, 0, 0, 0, 0, 0);

    // back-to-back burst of inserts spread over the bins
    quiet = 1;
    foreach (bin_used[i]) bin_used[i] = 0;
    placed = 0;
    while (placed < 300) begin
      c = {$urandom(), $urandom(), $urandom(), $urandom()};
      k = u_chk.bin_index(c);
      if (bin_used[k] < WaysDef) begin
        bin_used[k]++;
        placed++;
        send(KindInsert, c[0], c[1], c[2], c[3], 0);
      end
    end
    quiet = 0;
    send(KindInsert, 5, 6, 7, 8, 0);
    send(KindLookupIns, 9, 9, 9, 9, 0);
    send(KindRead, 0, 0, 0, 0, 12'hfff);
    send(KindLookup, c[0], c[1], c[2], c[3], 0);
    wait (pending == 0);
    send(KindClear, 0, 0, 0, 0, 0);

    // random mix over a small coordinate pool so hits and full bins recur
    for (int n = 0; n < 1320; n++) begin
      int unsigned sel;
      quiet = (n >= 600 && n < 800);
      if (n == 1000) wait (pending == 0);
      sel = $urandom_range(0, 99);
      c = {pick_coord(), pick_coord(), pick_coord(), pick_coord()};
      if (sel < 25)      send(KindLookup, c[0], c[1], c[2], c[3], 12'($urandom()));
      else if (sel < 58) send(KindLookupIns, c[0], c[1], c[2], c[3], 12'($urandom()));
      else if (sel < 72) send(KindInsert, c[0], c[1], c[2], c[3], 12'($urandom()));
      else if (sel < 94)
        send(KindRead, c[0], c[1], c[2], c[3],
             12'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 80)));
      else if (sel < 96) send(KindClear, c[0], c[1], c[2], c[3], 12'($urandom()));
      else send(3'($urandom_range(5, 7)), c[0], c[1], c[2], c[3], 12'($urandom()));
    end
    quiet = 0;

    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
